@@ design/bca_pkg.sv @@
// Shared constants, codes and handshake structs for the block chain allocator.
// Used by the controller, the datapath, the top level and the checker.
package bca_pkg;

   localparam int NUM_BLOCKS = 4096;
   localparam int BLOCK_W    = $clog2(NUM_BLOCKS);
   localparam int ROW_BITS   = 16;
   localparam int ROW_IDX_W  = $clog2(ROW_BITS);
   localparam int ROWS       = NUM_BLOCKS / ROW_BITS;
   localparam int ROW_W      = $clog2(ROWS);
   localparam int FIELD_W    = 16;
   localparam int COUNT_W    = 13;
   localparam int MODE_W     = 3;
   localparam int STATUS_W   = 2;
   localparam int RES_W      = 3;

   localparam logic [FIELD_W-1:0] END_MARK = 16'hFFFF;

   localparam logic [MODE_W-1:0] MODE_FORMAT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_START  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_APPEND = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FREE   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

   // Which values the result word is built from.
   localparam logic [RES_W-1:0] RES_NONE   = 3'd0;
   localparam logic [RES_W-1:0] RES_NOFREE = 3'd1;
   localparam logic [RES_W-1:0] RES_RANGE  = 3'd2;
   localparam logic [RES_W-1:0] RES_ALLOC  = 3'd3;
   localparam logic [RES_W-1:0] RES_LINK   = 3'd4;
   localparam logic [RES_W-1:0] RES_FREED  = 3'd5;

   typedef struct packed {
      logic             accept;
      logic             sweep_begin;
      logic             sweep_step;
      logic             scan_read;
      logic             scan_next;
      logic             scan_take;
      logic             append_link;
      logic             walk_begin;
      logic             walk_read;
      logic             walk_update;
      logic             link_read;
      logic             finish;
      logic [RES_W-1:0] result;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              block_bad;
      logic              total_zero;
      logic              row_hit;
      logic              walk_done;
      logic              sweep_last;
   } stat_type;

   // Index of the lowest set bit of a free map row; the row is known non-zero.
   function automatic logic [ROW_IDX_W-1:0] lowest_set(input logic [ROW_BITS-1:0] row);
      logic [ROW_BITS-1:0]  onehot;
      logic [ROW_IDX_W-1:0] idx;
      onehot = row & (~row + ROW_BITS'(1));
      idx = '0;
      for (int i = 0; i < ROW_BITS; i++) begin
         idx = idx | (onehot[i] ? ROW_IDX_W'(i) : ROW_IDX_W'(0));
      end
      return idx;
   endfunction

endpackage

@@ design/bca_ctrl.sv @@
// Controller state machine of the block chain allocator.
// Drives the datapath through bca_pkg::cmd_type and reads bca_pkg::stat_type.
module bca_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bca_pkg::stat_type stat,
   output bca_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_SWEEP    = 4'd2;
   localparam logic [3:0] S_SCAN     = 4'd3;
   localparam logic [3:0] S_APPEND   = 4'd4;
   localparam logic [3:0] S_WALK_RD  = 4'd5;
   localparam logic [3:0] S_WALK_UPD = 4'd6;
   localparam logic [3:0] S_LINK     = 4'd7;

   logic [3:0] state_ff, state_in;
   logic       report_ff, report_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         // The store is swept once after reset, without a result.
         state_ff  <= S_SWEEP;
         report_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         report_ff <= report_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in  = state_ff;
      report_in = report_ff;
      cmd       = '0;
      cmd.result = bca_pkg::RES_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.mode)
               bca_pkg::MODE_FORMAT: begin
                  cmd.sweep_begin = 1'b1;
                  report_in       = 1'b1;
                  state_in        = S_SWEEP;
               end
               bca_pkg::MODE_START: begin
                  if (stat.total_zero) begin
                     cmd.finish = 1'b1;
                     cmd.result = bca_pkg::RES_NOFREE;
                     state_in   = S_IDLE;
                  end else begin
                     cmd.scan_read = 1'b1;
                     state_in      = S_SCAN;
                  end
               end
               bca_pkg::MODE_APPEND: begin
                  if (stat.block_bad) begin
                     cmd.finish = 1'b1;
                     cmd.result = bca_pkg::RES_RANGE;
                     state_in   = S_IDLE;
                  end else if (stat.total_zero) begin
                     cmd.finish = 1'b1;
                     cmd.result = bca_pkg::RES_NOFREE;
                     state_in   = S_IDLE;
                  end else begin
                     cmd.scan_read = 1'b1;
                     state_in      = S_SCAN;
                  end
               end
               bca_pkg::MODE_FREE: begin
                  if (stat.block_bad) begin
                     cmd.finish = 1'b1;
                     cmd.result = bca_pkg::RES_RANGE;
                     state_in   = S_IDLE;
                  end else begin
                     cmd.walk_begin = 1'b1;
                     state_in       = S_WALK_RD;
                  end
               end
               bca_pkg::MODE_READ: begin
                  if (stat.block_bad) begin
                     cmd.finish = 1'b1;
                     cmd.result = bca_pkg::RES_RANGE;
                     state_in   = S_IDLE;
                  end else begin
                     cmd.link_read = 1'b1;
                     state_in      = S_LINK;
                  end
               end
               default: begin
                  cmd.finish = 1'b1;
                  cmd.result = bca_pkg::RES_NONE;
                  state_in   = S_IDLE;
               end
            endcase
         end
         S_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last) begin
               cmd.finish = report_ff;
               cmd.result = bca_pkg::RES_NONE;
               report_in  = 1'b0;
               state_in   = S_IDLE;
            end
         end
         S_SCAN: begin
            if (stat.row_hit) begin
               cmd.scan_take = 1'b1;
               if (stat.mode == bca_pkg::MODE_APPEND) begin
                  state_in = S_APPEND;
               end else begin
                  cmd.finish = 1'b1;
                  cmd.result = bca_pkg::RES_ALLOC;
                  state_in   = S_IDLE;
               end
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         S_APPEND: begin
            cmd.append_link = 1'b1;
            cmd.finish      = 1'b1;
            cmd.result      = bca_pkg::RES_ALLOC;
            state_in        = S_IDLE;
         end
         S_WALK_RD: begin
            if (stat.walk_done) begin
               cmd.finish = 1'b1;
               cmd.result = bca_pkg::RES_FREED;
               state_in   = S_IDLE;
            end else begin
               cmd.walk_read = 1'b1;
               state_in      = S_WALK_UPD;
            end
         end
         S_WALK_UPD: begin
            cmd.walk_update = 1'b1;
            state_in        = S_WALK_RD;
         end
         S_LINK: begin
            cmd.finish = 1'b1;
            cmd.result = bca_pkg::RES_LINK;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ design/bca_datapath.sv @@
// Datapath of the block chain allocator: free map and link memories, search
// hint, chain walker, counters and the result register. Uses bca_pkg.
module bca_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  bca_pkg::cmd_type                  cmd,
   output bca_pkg::stat_type                 stat,
   input  logic [bca_pkg::MODE_W-1:0]        req_mode,
   input  logic [bca_pkg::FIELD_W-1:0]       req_block,
   input  logic                              csr_write_enable,
   input  logic [bca_pkg::COUNT_W-1:0]       csr_write_data,
   output logic                              rsp_valid,
   output logic [bca_pkg::STATUS_W-1:0]      rsp_status,
   output logic [bca_pkg::FIELD_W-1:0]       rsp_block_out,
   output logic [bca_pkg::COUNT_W-1:0]       rsp_freed_count,
   output logic [bca_pkg::COUNT_W-1:0]       rsp_free_blocks
);

   localparam int BW = bca_pkg::BLOCK_W;
   localparam int RB = bca_pkg::ROW_BITS;
   localparam int RW = bca_pkg::ROW_W;
   localparam int RI = bca_pkg::ROW_IDX_W;
   localparam int CW = bca_pkg::COUNT_W;
   localparam int FW = bca_pkg::FIELD_W;
   localparam logic [CW-1:0] NB_COUNT = CW'(bca_pkg::NUM_BLOCKS);
   localparam logic [FW-1:0] NB_FIELD = FW'(bca_pkg::NUM_BLOCKS);

   logic [RB-1:0] fm_mem [bca_pkg::ROWS];
   logic [FW-1:0] link_mem [bca_pkg::NUM_BLOCKS];
   logic [RB-1:0] fm_rd_ff;
   logic [FW-1:0] link_rd_ff;

   logic [CW-1:0] reserved_ff, reserved_in;
   logic [CW-1:0] total_ff, total_in;
   logic [RW-1:0] hint_ff, hint_in;
   logic [BW-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic [CW-1:0] sweep_r_ff, sweep_r_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [bca_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic [FW-1:0]                tail_ff, tail_in;
   logic [BW-1:0]                alloc_ff, alloc_in;
   logic [FW-1:0]                cur_ff, cur_in;
   logic [CW-1:0]                steps_ff, steps_in;
   logic [CW-1:0]                freed_ff, freed_in;
   logic [bca_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [FW-1:0]                rsp_block_ff, rsp_block_in;
   logic [CW-1:0]                rsp_freed_ff, rsp_freed_in;
   logic [CW-1:0]                rsp_total_ff, rsp_total_in;

   logic          fm_we, fm_re, link_we, link_re;
   logic [RW-1:0] fm_waddr, fm_raddr;
   logic [RB-1:0] fm_wdata;
   logic [BW-1:0] link_waddr, link_raddr;
   logic [FW-1:0] link_wdata;

   logic [CW-1:0] r_eff;
   logic [CW-1:0] row_base, row_end;
   logic [RB-1:0] sweep_mask;
   logic [RI-1:0] hit_idx;
   logic [RB-1:0] cur_onehot;
   logic [RW-1:0] cur_row;
   logic          cur_free;

   always_ff @(posedge clock) begin
      if (fm_we) begin
         fm_mem[fm_waddr] <= fm_wdata;
      end
      if (fm_re) begin
         fm_rd_ff <= fm_mem[fm_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (link_re) begin
         link_rd_ff <= link_mem[link_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff  <= '0;
         total_ff     <= NB_COUNT;
         hint_ff      <= '0;
         sweep_cnt_ff <= '0;
         sweep_r_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         reserved_ff  <= reserved_in;
         total_ff     <= total_in;
         hint_ff      <= hint_in;
         sweep_cnt_ff <= sweep_cnt_in;
         sweep_r_ff   <= sweep_r_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      tail_ff       <= tail_in;
      alloc_ff      <= alloc_in;
      cur_ff        <= cur_in;
      steps_ff      <= steps_in;
      freed_ff      <= freed_in;
      rsp_status_ff <= rsp_status_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_freed_ff  <= rsp_freed_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign r_eff = (reserved_ff > NB_COUNT) ? NB_COUNT : reserved_ff;

   // Row of the sweep: bits below the latched reserved count are used.
   assign row_base = CW'({sweep_cnt_ff[RW-1:0], RI'(0)});
   assign row_end  = row_base + CW'(RB);
   always_comb begin
      if (sweep_r_ff >= row_end) begin
         sweep_mask = '0;
      end else if (sweep_r_ff <= row_base) begin
         sweep_mask = '1;
      end else begin
         sweep_mask = ~((RB'(1) << sweep_r_ff[RI-1:0]) - RB'(1));
      end
   end

   assign hit_idx    = bca_pkg::lowest_set(fm_rd_ff);
   assign cur_row    = cur_ff[BW-1:RI];
   assign cur_onehot = RB'(1) << cur_ff[RI-1:0];
   assign cur_free   = fm_rd_ff[cur_ff[RI-1:0]];

   always_comb begin
      stat.mode       = mode_ff;
      stat.block_bad  = (tail_ff >= NB_FIELD);
      stat.total_zero = (total_ff == '0);
      stat.row_hit    = (fm_rd_ff != '0);
      stat.walk_done  = (cur_ff >= NB_FIELD) || (steps_ff == NB_COUNT);
      stat.sweep_last = (sweep_cnt_ff == BW'(bca_pkg::NUM_BLOCKS - 1));
   end

   always_comb begin
      reserved_in   = csr_write_enable ? csr_write_data : reserved_ff;
      total_in      = total_ff;
      hint_in       = hint_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      sweep_r_in    = sweep_r_ff;
      mode_in       = mode_ff;
      tail_in       = tail_ff;
      alloc_in      = alloc_ff;
      cur_in        = cur_ff;
      steps_in      = steps_ff;
      freed_in      = freed_ff;
      rsp_valid_in  = cmd.finish;
      rsp_status_in = rsp_status_ff;
      rsp_block_in  = rsp_block_ff;
      rsp_freed_in  = rsp_freed_ff;
      rsp_total_in  = rsp_total_ff;

      fm_we      = 1'b0;
      fm_waddr   = hint_ff;
      fm_wdata   = fm_rd_ff;
      fm_re      = 1'b0;
      fm_raddr   = hint_ff;
      link_we    = 1'b0;
      link_waddr = sweep_cnt_ff;
      link_wdata = bca_pkg::END_MARK;
      link_re    = 1'b0;
      link_raddr = tail_ff[BW-1:0];

      if (cmd.accept) begin
         mode_in = req_mode;
         tail_in = req_block;
      end

      if (cmd.sweep_begin) begin
         sweep_cnt_in = '0;
         sweep_r_in   = r_eff;
         total_in     = NB_COUNT - r_eff;
         hint_in      = r_eff[BW-1:RI];
      end

      if (cmd.sweep_step) begin
         sweep_cnt_in = sweep_cnt_ff + BW'(1);
         link_we      = 1'b1;
         link_waddr   = sweep_cnt_ff;
         link_wdata   = bca_pkg::END_MARK;
         if (sweep_cnt_ff < BW'(bca_pkg::ROWS)) begin
            fm_we    = 1'b1;
            fm_waddr = sweep_cnt_ff[RW-1:0];
            fm_wdata = sweep_mask;
         end
      end

      if (cmd.scan_read) begin
         fm_re    = 1'b1;
         fm_raddr = hint_ff;
      end

      // Every row below the hint is known to be full.
      if (cmd.scan_next) begin
         hint_in  = hint_ff + RW'(1);
         fm_re    = 1'b1;
         fm_raddr = hint_ff + RW'(1);
      end

      if (cmd.scan_take) begin
         alloc_in   = {hint_ff, hit_idx};
         total_in   = total_ff - CW'(1);
         fm_we      = 1'b1;
         fm_waddr   = hint_ff;
         fm_wdata   = fm_rd_ff & ~(RB'(1) << hit_idx);
         link_we    = 1'b1;
         link_waddr = {hint_ff, hit_idx};
         link_wdata = bca_pkg::END_MARK;
      end

      if (cmd.append_link) begin
         link_we    = 1'b1;
         link_waddr = tail_ff[BW-1:0];
         link_wdata = FW'(alloc_ff);
      end

      if (cmd.walk_begin) begin
         cur_in   = tail_ff;
         steps_in = '0;
         freed_in = '0;
      end

      if (cmd.walk_read) begin
         fm_re      = 1'b1;
         fm_raddr   = cur_row;
         link_re    = 1'b1;
         link_raddr = cur_ff[BW-1:0];
      end

      if (cmd.walk_update) begin
         cur_in   = link_rd_ff;
         steps_in = steps_ff + CW'(1);
         if (!cur_free) begin
            fm_we    = 1'b1;
            fm_waddr = cur_row;
            fm_wdata = fm_rd_ff | cur_onehot;
            total_in = total_ff + CW'(1);
            freed_in = freed_ff + CW'(1);
            if (cur_row < hint_ff) begin
               hint_in = cur_row;
            end
         end
      end

      if (cmd.link_read) begin
         link_re    = 1'b1;
         link_raddr = tail_ff[BW-1:0];
      end

      if (cmd.finish) begin
         rsp_total_in = total_in;
         rsp_freed_in = '0;
         rsp_block_in = bca_pkg::END_MARK;
         unique case (cmd.result)
            bca_pkg::RES_NONE: begin
               rsp_status_in = bca_pkg::ST_OK;
            end
            bca_pkg::RES_NOFREE: begin
               rsp_status_in = bca_pkg::ST_NO_FREE;
            end
            bca_pkg::RES_RANGE: begin
               rsp_status_in = bca_pkg::ST_RANGE;
            end
            bca_pkg::RES_ALLOC: begin
               rsp_status_in = bca_pkg::ST_OK;
               rsp_block_in  = FW'(alloc_in);
            end
            bca_pkg::RES_LINK: begin
               rsp_status_in = bca_pkg::ST_OK;
               rsp_block_in  = link_rd_ff;
            end
            bca_pkg::RES_FREED: begin
               rsp_status_in = bca_pkg::ST_OK;
               rsp_freed_in  = freed_ff;
            end
            default: begin
               rsp_status_in = bca_pkg::ST_OK;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_block_out   = rsp_block_ff;
   assign rsp_freed_count = rsp_freed_ff;
   assign rsp_free_blocks = rsp_total_ff;

endmodule

@@ design/block_chain_allocator.sv @@
// Work per request: a rejected or unused mode is answered from the decode state, read link
// reads one link entry, start chain searches bitmap rows from the hint (append then writes
// the link), free chain reads and updates each chain block in turn, and format sweeps the
// link table, whose sweep writes one entry a cycle.
// One request is in work at a time; the next is taken in the cycle its word is shown.
// Reset is synchronous; afterwards busy stays high while the store is cleared.
module block_chain_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [bca_pkg::MODE_W-1:0]        req_mode,
   input  logic [bca_pkg::FIELD_W-1:0]       req_block,
   input  logic                              csr_write_enable,
   input  logic [bca_pkg::COUNT_W-1:0]       csr_write_data,
   output logic                              rsp_valid,
   output logic [bca_pkg::STATUS_W-1:0]      rsp_status,
   output logic [bca_pkg::FIELD_W-1:0]       rsp_block_out,
   output logic [bca_pkg::COUNT_W-1:0]       rsp_freed_count,
   output logic [bca_pkg::COUNT_W-1:0]       rsp_free_blocks
);

   bca_pkg::cmd_type  cmd;
   bca_pkg::stat_type stat;

   bca_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   bca_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_mode         (req_mode),
      .req_block        (req_block),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_block_out    (rsp_block_out),
      .rsp_freed_count  (rsp_freed_count),
      .rsp_free_blocks  (rsp_free_blocks)
   );

endmodule

@@ design/bca_checker.sv @@
// Port level checks for the block chain allocator, bound to the top level.
// Depends on bca_pkg for widths and status codes.
module bca_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic [bca_pkg::STATUS_W-1:0]      rsp_status,
   input logic [bca_pkg::FIELD_W-1:0]       rsp_block_out,
   input logic [bca_pkg::COUNT_W-1:0]       rsp_freed_count
);

   // An accepted word always makes the block busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   // A result ends the work on its word, so two never come back to back.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   // A refused request neither allocates nor frees anything.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bca_pkg::ST_OK
         |-> rsp_block_out == bca_pkg::END_MARK && rsp_freed_count == '0)
      else $error("refused request carried a block or a freed count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == bca_pkg::ST_OK || rsp_status == bca_pkg::ST_NO_FREE
                    || rsp_status == bca_pkg::ST_RANGE)
      else $error("undefined status code");

endmodule

bind block_chain_allocator bca_checker u_bca_checker (.*);
